// ----- hdl/swbl_pkg.sv -----
// ----------------------------------------------------------------------------
// swbl_pkg
// Shared types and constants for the subtract-with-borrow luxury generator.
// ----------------------------------------------------------------------------
package swbl_pkg;

  localparam int unsigned LONG_LAG_DEF  = 43;
  localparam int unsigned SHORT_LAG_DEF = 22;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned LUX_W  = 4;

  localparam logic [WORD_W-1:0] SWB_MODULUS = 32'hFFFF_FFFB;

  // Request type codes.
  localparam logic REQ_SEED     = 1'b0;
  localparam logic REQ_GENERATE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC
  } swbl_state_e;

  // Result of one subtract-with-borrow step.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              borrow;
  } swbl_step_t;

endpackage

// ----- hdl/swbl_ram.sv -----
// ----------------------------------------------------------------------------
// swbl_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module swbl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 44
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ----- hdl/swbl_alu.sv -----
// ----------------------------------------------------------------------------
// swbl_alu
// One subtract-with-borrow step modulo 2^32-5.
// ----------------------------------------------------------------------------
module swbl_alu
  import swbl_pkg::*;
(
  input  logic [WORD_W-1:0] xj_i,
  input  logic [WORD_W-1:0] xi_i,
  input  logic              borrow_i,
  output swbl_step_t        res_o
);

  logic [WORD_W:0] sub;
  logic [WORD_W:0] diff;

  always_comb begin
    sub  = {1'b0, xi_i} + {{WORD_W{1'b0}}, borrow_i};
    diff = {1'b0, xj_i} - sub;
    // The top bit of the 33-bit difference is set exactly when xj < xi + borrow.
    res_o.borrow = diff[WORD_W];
    res_o.word   = diff[WORD_W] ? (diff[WORD_W-1:0] + SWB_MODULUS) : diff[WORD_W-1:0];
  end

endmodule

// ----- hdl/swb_luxury_prng_core.sv -----
// ----------------------------------------------------------------------------
// swb_luxury_prng_core
// Subtract-with-borrow generator with lags LONG_LAG/SHORT_LAG and luxury level.
// ----------------------------------------------------------------------------
// A seed request is taken while idle and the block stays ready for the next
// request. A generate request is accepted in IDLE, and the input then stays
// stalled through READ, which reads both lag words from the two-port table
// RAM, and CALC, which does the subtract and write-back. Once every LONG_LAG
// generate requests, LONG_LAG*luxury_level discarded steps run first, each
// needing its own RAM read and write-back. The final step waits while the
// previous word still sits in the output register.
// The table reads as zero until each entry is written; no clearing pass is
// needed after reset.
module swb_luxury_prng_core
  import swbl_pkg::*;
#(
  parameter int unsigned LONG_LAG  = LONG_LAG_DEF,
  parameter int unsigned SHORT_LAG = SHORT_LAG_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LUX_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              req_type_i,
  input  logic [WORD_W-1:0] seed_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [WORD_W-1:0] random_word_o
);

  localparam int unsigned IDX_W  = $clog2(LONG_LAG + 1);
  localparam int unsigned DISC_W = $clog2(LONG_LAG * ((1 << LUX_W) - 1) + 1);
  localparam int unsigned SHORT_INIT =
      (SHORT_LAG < 1 || SHORT_LAG > LONG_LAG) ? LONG_LAG : SHORT_LAG;

  localparam logic [IDX_W-1:0]  LAG_IDX   = IDX_W'(LONG_LAG);
  localparam logic [IDX_W-1:0]  SHORT_IDX = IDX_W'(SHORT_INIT);
  localparam logic [IDX_W-1:0]  ONE_IDX   = IDX_W'(1);
  localparam logic [IDX_W-1:0]  TWO_IDX   = IDX_W'(2);
  localparam logic [DISC_W-1:0] LAG_DISC  = DISC_W'(LONG_LAG);

  swbl_state_e state_q, state_d;

  logic [IDX_W-1:0]  long_idx_q, long_idx_d;
  logic [IDX_W-1:0]  short_idx_q, short_idx_d;
  logic [IDX_W-1:0]  out_pos_q, out_pos_d;
  logic [IDX_W-1:0]  seed_pos_q, seed_pos_d;
  logic [DISC_W-1:0] discard_q, discard_d;
  logic              borrow_q, borrow_d;
  logic [LUX_W-1:0]  lux_q;
  logic [LONG_LAG:0] filled_q, filled_d;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] out_word_q, out_word_d;

  logic              filled_s_q, filled_l_q;
  logic              in_accept;
  logic              last_step;
  logic              out_free;
  logic              commit;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] rdata_s, rdata_l;
  logic [WORD_W-1:0] xj, xi;
  swbl_step_t        step_res;

  logic [IDX_W-1:0]  seed_k;
  logic [IDX_W-1:0]  pos_inc;
  logic [WORD_W-1:0] seed_w;

  swbl_ram #(
    .WIDTH (WORD_W),
    .DEPTH (LONG_LAG + 1)
  ) u_lag_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (short_idx_q),
    .raddr_b_i (long_idx_q),
    .rdata_a_o (rdata_s),
    .rdata_b_o (rdata_l)
  );

  // Fill flags are sampled alongside the RAM read so both line up in CALC.
  always_ff @(posedge clk_i) begin
    filled_s_q <= filled_q[short_idx_q];
    filled_l_q <= filled_q[long_idx_q];
  end

  assign xj = filled_s_q ? rdata_s : '0;
  assign xi = filled_l_q ? rdata_l : '0;

  swbl_alu u_alu (
    .xj_i     (xj),
    .xi_i     (xi),
    .borrow_i (borrow_q),
    .res_o    (step_res)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && (state_q == ST_IDLE);
  assign last_step  = (discard_q == '0);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign commit     = (state_q == ST_CALC) && (!last_step || out_free);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && req_type_i == REQ_GENERATE) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CALC;
      end
      ST_CALC: begin
        if (commit) begin
          state_d = last_step ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath control and register updates.
  always_comb begin
    long_idx_d  = long_idx_q;
    short_idx_d = short_idx_q;
    out_pos_d   = out_pos_q;
    seed_pos_d  = seed_pos_q;
    discard_d   = discard_q;
    borrow_d    = borrow_q;
    filled_d    = filled_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;
    ram_we      = 1'b0;
    ram_waddr   = long_idx_q;
    ram_wdata   = step_res.word;

    seed_k  = seed_pos_q + ONE_IDX;
    pos_inc = out_pos_q + ONE_IDX;
    seed_w  = seed_word_i;
    if (seed_k == ONE_IDX) begin
      seed_w[0] = 1'b1;
    end else if (seed_k == TWO_IDX) begin
      seed_w[0] = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && req_type_i == REQ_SEED) begin
          ram_we           = 1'b1;
          ram_waddr        = seed_k;
          ram_wdata        = seed_w;
          filled_d[seed_k] = 1'b1;
          if (seed_k >= LAG_IDX) begin
            borrow_d    = 1'b1;
            long_idx_d  = LAG_IDX;
            short_idx_d = SHORT_IDX;
            out_pos_d   = '0;
            seed_pos_d  = '0;
          end else begin
            seed_pos_d = seed_k;
          end
        end else if (in_accept) begin
          // Every LONG_LAG requests, a luxury block of discarded steps runs first.
          if (pos_inc >= LAG_IDX) begin
            out_pos_d = '0;
            discard_d = LAG_DISC * DISC_W'(lux_q);
          end else begin
            out_pos_d = pos_inc;
          end
        end
      end
      ST_READ: begin
      end
      ST_CALC: begin
        if (commit) begin
          ram_we               = 1'b1;
          filled_d[long_idx_q] = 1'b1;
          borrow_d             = step_res.borrow;
          long_idx_d           = (long_idx_q == ONE_IDX) ? LAG_IDX : long_idx_q - ONE_IDX;
          short_idx_d          = (short_idx_q == ONE_IDX) ? LAG_IDX : short_idx_q - ONE_IDX;
          if (last_step) begin
            out_valid_d = 1'b1;
            out_word_d  = step_res.word;
          end else begin
            discard_d = discard_q - DISC_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      long_idx_q  <= LAG_IDX;
      short_idx_q <= SHORT_IDX;
      out_pos_q   <= '0;
      seed_pos_q  <= '0;
      discard_q   <= '0;
      borrow_q    <= 1'b1;
      lux_q       <= '0;
      filled_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      long_idx_q  <= long_idx_d;
      short_idx_q <= short_idx_d;
      out_pos_q   <= out_pos_d;
      seed_pos_q  <= seed_pos_d;
      discard_q   <= discard_d;
      borrow_q    <= borrow_d;
      filled_q    <= filled_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        lux_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o   = out_valid_q;
  assign random_word_o = out_word_q;

  // The READ state is always followed by CALC in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> state_q == ST_CALC)
    else $error("table read not followed by step cycle");

  // Both lag pointers stay within the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    long_idx_q >= ONE_IDX && long_idx_q <= LAG_IDX &&
    short_idx_q >= ONE_IDX && short_idx_q <= LAG_IDX)
    else $error("lag index out of range");

  // No discarded steps may be pending once the block is ready again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> discard_q == '0)
    else $error("discard count left over in idle");

  // The final step of a request always leaves a word in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && last_step |=> out_valid_o && state_q == ST_IDLE)
    else $error("final step did not deliver a word");

endmodule
